FILE: rtl/core/tsdfv_pkg.sv
// Package for the TSDF voxel depth integration core: store geometry,
// register indexes, widths and the sideband word type.
// No dependencies.
`default_nettype none

package tsdfv_pkg;

    localparam int MAX_IMAGE_WIDTH  = 1024;
    localparam int MAX_IMAGE_HEIGHT = 1024;

    localparam int COL_W   = $clog2(MAX_IMAGE_WIDTH);
    localparam int ROW_W   = $clog2(MAX_IMAGE_HEIGHT);
    localparam int ADDR_W  = COL_W + ROW_W;
    localparam int DEPTH   = MAX_IMAGE_WIDTH * MAX_IMAGE_HEIGHT;

    // one quotient bit more than the largest in-range position needs,
    // so that anything at or past the limit shows up as out of range
    localparam int QB      = ((COL_W > ROW_W) ? COL_W : ROW_W) + 1;

    localparam int NUM_W   = 50;            // 2*h + hz, signed
    localparam int DEN_W   = 49;            // |2*hz|, unsigned
    localparam int REM_W   = DEN_W + QB;    // divisor shifted by the top bit

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_TRUNC_DISTANCE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_THICKNESS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_SLOPE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_MAGNITUDE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FREESPACE_VALUE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OCCLUDED_VALUE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT    = 3'd7;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_VOXEL = 1'b1;

    localparam logic [1:0] POT_SLOPE = 2'd0;
    localparam logic [1:0] POT_PEAK  = 2'd1;
    localparam logic [1:0] POT_TRUNC = 2'd2;

    // what travels beside the divider
    typedef struct packed {
        logic               cmd;
        logic [9:0]         col;
        logic [9:0]         row;
        logic [31:0]        depth;
        logic [15:0]        weight;
        logic signed [47:0] hz;
        logic signed [31:0] vox;
        logic               skip;
    } t_side;

endpackage

`default_nettype wire

FILE: rtl/core/tsdfv_in_if.sv
// Input channel of the TSDF voxel depth integration core.
// Depends on nothing.
`default_nettype none

interface tsdfv_in_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic [9:0]         pixel_col;
    logic [9:0]         pixel_row;
    logic [31:0]        depth_sample;
    logic [15:0]        weight_sample;
    logic signed [47:0] proj_x;
    logic signed [47:0] proj_y;
    logic signed [47:0] proj_z;
    logic signed [31:0] voxel_value;

    modport source (output valid, cmd, pixel_col, pixel_row, depth_sample, weight_sample,
                    proj_x, proj_y, proj_z, voxel_value, input ready);
    modport sink (input valid, cmd, pixel_col, pixel_row, depth_sample, weight_sample,
                  proj_x, proj_y, proj_z, voxel_value, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/tsdfv_out_if.sv
// Result channel of the TSDF voxel depth integration core.
// Depends on nothing.
`default_nettype none

interface tsdfv_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] new_voxel_value;
    logic signed [31:0] contribution;
    logic               in_view;
    logic               saturated;

    modport source (output valid, new_voxel_value, contribution, in_view, saturated,
                    input ready);
    modport sink (input valid, new_voxel_value, contribution, in_view, saturated,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/core/tsdfv_div.sv
// Pipelined restoring divider, two lanes sharing one divisor, one
// quotient bit per stage. Depends on tsdfv_pkg.
`default_nettype none

module tsdfv_div import tsdfv_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [DEN_W-1:0] i_num_x,
    input  wire logic [DEN_W-1:0] i_num_y,
    input  wire logic [DEN_W-1:0] i_den,
    output logic      [QB-1:0]    o_q_x,
    output logic      [QB-1:0]    o_q_y
);

    logic [REM_W-1:0] r_rx [0:QB];
    logic [REM_W-1:0] r_ry [0:QB];
    logic [REM_W-1:0] r_d  [0:QB-1];
    logic [QB-1:0]    r_qx [0:QB];
    logic [QB-1:0]    r_qy [0:QB];

    logic [REM_W-1:0] n_rx [1:QB];
    logic [REM_W-1:0] n_ry [1:QB];
    logic [QB-1:0]    n_qx [1:QB];
    logic [QB-1:0]    n_qy [1:QB];

    // stage s resolves quotient bit QB-s
    always_comb begin
        for (int s = 1; s <= QB; s++) begin
            logic [REM_W-1:0] sd;
            sd = r_d[s-1] << (QB - s);
            n_rx[s] = r_rx[s-1];
            n_ry[s] = r_ry[s-1];
            n_qx[s] = r_qx[s-1];
            n_qy[s] = r_qy[s-1];
            if (r_rx[s-1] >= sd) begin
                n_rx[s] = r_rx[s-1] - sd;
                n_qx[s][QB-s] = 1'b1;
            end
            if (r_ry[s-1] >= sd) begin
                n_ry[s] = r_ry[s-1] - sd;
                n_qy[s][QB-s] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rx[0] <= REM_W'(i_num_x);
            r_ry[0] <= REM_W'(i_num_y);
            r_d[0]  <= REM_W'(i_den);
            r_qx[0] <= '0;
            r_qy[0] <= '0;
            for (int s = 1; s <= QB; s++) begin
                r_rx[s] <= n_rx[s];
                r_ry[s] <= n_ry[s];
                if (s < QB) r_d[s] <= r_d[s-1];
                r_qx[s] <= n_qx[s];
                r_qy[s] <= n_qy[s];
            end
        end
    end

    assign o_q_x = r_qx[QB];
    assign o_q_y = r_qy[QB];

endmodule

`default_nettype wire

FILE: rtl/core/tsdf_voxel_depth_integration_core.sv
// Top level of the TSDF voxel depth integration core: depth/weight store,
// projection divider, ray potential and weighted accumulation.
// Depends on tsdfv_pkg, tsdfv_in_if, tsdfv_out_if and tsdfv_div.
`default_nettype none

// channel   dir  word
// --------  ---  -----------------------------------------------------------
// i_in      in   cmd, pixel_col/row, depth/weight_sample, proj_x/y/z, voxel_value
// o_out     out  new_voxel_value, contribution, in_view, saturated
// i_cfg_*   in   register index and 32-bit data, one write per cycle
//
// One word per cycle in and out while no result waits unread. A voxel word's
// result passes the capture stage, the divider (QB = 11 divider stages at a
// 1024 pixel store), stages A, M, P1 to P5 and the output register; a load
// word gives no result. The store is one array of MAX_IMAGE_WIDTH*MAX_IMAGE_HEIGHT
// entries with one port, touched by each word in the same stage, so loads and
// lookups keep input order. Reset clears valid bits and registers only; the
// store needs no clearing. A stall on the result side freezes every stage.

module tsdf_voxel_depth_integration_core import tsdfv_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    tsdfv_in_if.sink                   i_in,
    tsdfv_out_if.source                o_out,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    // configuration
    logic [31:0]        r_trunc;
    logic [31:0]        r_thick;
    logic [31:0]        r_slope;
    logic [30:0]        r_peak;
    logic signed [31:0] r_free;
    logic [30:0]        r_occ;
    logic [10:0]        r_img_w;
    logic [10:0]        r_img_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trunc <= 32'd655360;
            r_thick <= 32'd1310720;
            r_slope <= 32'd3276;
            r_peak  <= 31'd65536;
            r_free  <= -32'sd65536;
            r_occ   <= 31'd655;
            r_img_w <= 11'd1024;
            r_img_h <= 11'd1024;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_TRUNC_DISTANCE:  r_trunc <= i_cfg_data;
                REG_BAND_THICKNESS:  r_thick <= i_cfg_data;
                REG_BAND_SLOPE:      r_slope <= i_cfg_data;
                REG_PEAK_MAGNITUDE:  r_peak  <= i_cfg_data[30:0];
                REG_FREESPACE_VALUE: r_free  <= $signed(i_cfg_data);
                REG_OCCLUDED_VALUE:  r_occ   <= i_cfg_data[30:0];
                REG_IMAGE_WIDTH:     r_img_w <= i_cfg_data[10:0];
                REG_IMAGE_HEIGHT:    r_img_h <= i_cfg_data[10:0];
                default: ;
            endcase
        end
    end

    // global advance: hold every stage while a result waits unread
    logic r_out_valid;
    logic en;
    assign en = !r_out_valid || o_out.ready;
    assign i_in.ready = en;

    // ---------------- stage 1: capture the word ----------------
    logic               r_s1_v;
    logic               r_s1_cmd;
    logic [9:0]         r_s1_col, r_s1_row;
    logic [31:0]        r_s1_depth;
    logic [15:0]        r_s1_weight;
    logic signed [47:0] r_s1_hx, r_s1_hy, r_s1_hz;
    logic signed [31:0] r_s1_vox;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_cmd    <= i_in.cmd;
            r_s1_col    <= i_in.pixel_col;
            r_s1_row    <= i_in.pixel_row;
            r_s1_depth  <= i_in.depth_sample;
            r_s1_weight <= i_in.weight_sample;
            r_s1_hx     <= i_in.proj_x;
            r_s1_hy     <= i_in.proj_y;
            r_s1_hz     <= i_in.proj_z;
            r_s1_vox    <= i_in.voxel_value;
        end
    end

    // fold the sign of hz into numerator and divisor; round by adding half
    logic signed [NUM_W:0] nx, ny, dd, sx, sy;
    logic                  hz_neg, hz_zero, neg_x, neg_y;
    logic [DEN_W-1:0]      num_x, num_y, den;
    t_side                 side;

    always_comb begin
        hz_neg  = r_s1_hz[47];
        hz_zero = (r_s1_hz == '0);
        nx = ((NUM_W+1)'(r_s1_hx) <<< 1) + (NUM_W+1)'(r_s1_hz);
        ny = ((NUM_W+1)'(r_s1_hy) <<< 1) + (NUM_W+1)'(r_s1_hz);
        dd = (NUM_W+1)'(r_s1_hz) <<< 1;
        if (hz_neg) begin
            nx = -nx;
            ny = -ny;
            dd = -dd;
        end
        // quotient at or below minus one when n <= -d
        sx = nx + dd;
        sy = ny + dd;
        neg_x = (sx <= 0);
        neg_y = (sy <= 0);
        num_x = nx[NUM_W] ? '0 : nx[DEN_W-1:0];
        num_y = ny[NUM_W] ? '0 : ny[DEN_W-1:0];
        den   = dd[DEN_W-1:0];
        side.cmd    = r_s1_cmd;
        side.col    = r_s1_col;
        side.row    = r_s1_row;
        side.depth  = r_s1_depth;
        side.weight = r_s1_weight;
        side.hz     = r_s1_hz;
        side.vox    = r_s1_vox;
        side.skip   = hz_zero || neg_x || neg_y;
    end

    // ---------------- divider stages ----------------
    logic [QB-1:0] q_x, q_y;

    tsdfv_div u_div (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_num_x (num_x),
        .i_num_y (num_y),
        .i_den   (den),
        .o_q_x   (q_x),
        .o_q_y   (q_y)
    );

    t_side r_sd [0:QB];
    logic  r_sv [0:QB];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sd[0] <= side;
            for (int s = 1; s <= QB; s++) r_sd[s] <= r_sd[s-1];
        end
    end

    // ---------------- stage A: range check, store address ----------------
    logic [31:0]       w_use, h_use, qx32, qy32, col32, row32;
    logic              view_pos, load_ok;
    logic [ADDR_W-1:0] n_addr;
    t_side             sa;

    always_comb begin
        sa    = r_sd[QB];
        w_use = (32'(r_img_w) > 32'(MAX_IMAGE_WIDTH)) ? 32'(MAX_IMAGE_WIDTH) : 32'(r_img_w);
        h_use = (32'(r_img_h) > 32'(MAX_IMAGE_HEIGHT)) ? 32'(MAX_IMAGE_HEIGHT) : 32'(r_img_h);
        qx32  = 32'(q_x);
        qy32  = 32'(q_y);
        col32 = 32'(sa.col);
        row32 = 32'(sa.row);
        view_pos = !sa.skip && (qx32 < w_use) && (qy32 < h_use);
        load_ok  = (col32 < 32'(MAX_IMAGE_WIDTH)) && (row32 < 32'(MAX_IMAGE_HEIGHT));
        if (sa.cmd == CMD_LOAD)
            n_addr = ADDR_W'((row32 << COL_W) | col32);
        else
            n_addr = ADDR_W'((qy32 << COL_W) | qx32);
    end

    logic               r_a_v, r_a_we, r_a_look, r_a_load;
    logic [ADDR_W-1:0]  r_a_addr;
    logic [47:0]        r_a_wdata;
    logic signed [47:0] r_a_hz;
    logic signed [31:0] r_a_vox;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_we    <= (sa.cmd == CMD_LOAD) && load_ok;
            r_a_load  <= (sa.cmd == CMD_LOAD);
            r_a_look  <= (sa.cmd == CMD_VOXEL) && view_pos;
            r_a_addr  <= n_addr;
            r_a_wdata <= {sa.depth, sa.weight};
            r_a_hz    <= sa.hz;
            r_a_vox   <= sa.vox;
        end
    end

    // ---------------- stage M: store access ----------------
    logic [47:0] r_mem [0:DEPTH-1];
    logic [47:0] r_m_rd;
    logic               r_m_v, r_m_look;
    logic signed [47:0] r_m_hz;
    logic signed [31:0] r_m_vox;

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_a_v && r_a_we)
                r_mem[r_a_addr] <= r_a_wdata;
            r_m_rd   <= r_mem[r_a_addr];
            r_m_look <= r_a_look;
            r_m_hz   <= r_a_hz;
            r_m_vox  <= r_a_vox;
        end
    end

    // ---------------- stage P1: depth difference, region ----------------
    logic [31:0]        m_d;
    logic [15:0]        m_a;
    logic signed [49:0] diff;
    logic [49:0]        ad;
    logic [1:0]         n_mode;

    always_comb begin
        m_d  = r_m_rd[47:16];
        m_a  = r_m_rd[15:0];
        diff = 50'(r_m_hz) - $signed({18'd0, m_d});
        ad   = diff[49] ? 50'(-diff) : 50'(diff);
        if (ad > 50'(r_trunc))
            n_mode = POT_TRUNC;
        else if (ad > 50'(r_thick))
            n_mode = POT_PEAK;
        else
            n_mode = POT_SLOPE;
    end

    logic               r_p1_v, r_p1_view, r_p1_pos, r_p1_neg;
    logic [1:0]         r_p1_mode;
    logic [31:0]        r_p1_ad;
    logic [15:0]        r_p1_a;
    logic signed [31:0] r_p1_vox;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p1_view <= r_m_look && (m_d != '0) && (m_a != '0);
            r_p1_pos  <= !diff[49] && (diff != '0);
            r_p1_neg  <= diff[49];
            r_p1_mode <= n_mode;
            r_p1_ad   <= ad[31:0];
            r_p1_a    <= m_a;
            r_p1_vox  <= r_m_vox;
        end
    end

    // ---------------- stage P2: slope product ----------------
    logic               r_p2_v, r_p2_view, r_p2_pos, r_p2_neg;
    logic [1:0]         r_p2_mode;
    logic [63:0]        r_p2_prod;
    logic [15:0]        r_p2_a;
    logic signed [31:0] r_p2_vox;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p2_prod <= 64'(r_p1_ad) * 64'(r_slope);
            r_p2_view <= r_p1_view;
            r_p2_pos  <= r_p1_pos;
            r_p2_neg  <= r_p1_neg;
            r_p2_mode <= r_p1_mode;
            r_p2_a    <= r_p1_a;
            r_p2_vox  <= r_p1_vox;
        end
    end

    // ---------------- stage P3: potential ----------------
    logic [47:0]        smag;
    logic signed [31:0] pot;
    logic               sat1;

    always_comb begin
        smag = r_p2_prod[63:16];
        sat1 = 1'b0;
        case (r_p2_mode)
            POT_TRUNC: pot = r_p2_pos ? $signed({1'b0, r_occ}) : r_free;
            POT_PEAK:  pot = r_p2_pos ? $signed({1'b0, r_peak}) : -$signed({1'b0, r_peak});
            POT_SLOPE: begin
                if (r_p2_neg) begin
                    if (smag > 48'h0000_8000_0000) begin
                        sat1 = 1'b1;
                        pot  = 32'sh8000_0000;
                    end else begin
                        pot = -$signed(smag[31:0]);
                    end
                end else if (smag > 48'h0000_7FFF_FFFF) begin
                    sat1 = 1'b1;
                    pot  = 32'sh7FFF_FFFF;
                end else begin
                    pot = $signed(smag[31:0]);
                end
            end
            default: pot = '0;
        endcase
    end

    logic               r_p3_v, r_p3_view, r_p3_sat;
    logic signed [31:0] r_p3_pot;
    logic [15:0]        r_p3_a;
    logic signed [31:0] r_p3_vox;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p3_pot  <= pot;
            r_p3_sat  <= sat1 && r_p2_view;
            r_p3_view <= r_p2_view;
            r_p3_a    <= r_p2_a;
            r_p3_vox  <= r_p2_vox;
        end
    end

    // ---------------- stage P4: weight product ----------------
    logic               r_p4_v, r_p4_view, r_p4_sat, r_p4_neg;
    logic [47:0]        r_p4_prod;
    logic signed [31:0] r_p4_vox;
    logic [31:0]        pmag;

    assign pmag = r_p3_pot[31] ? 32'(-r_p3_pot) : 32'(r_p3_pot);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p4_prod <= 48'(pmag) * 48'(r_p3_a);
            r_p4_neg  <= r_p3_pot[31];
            r_p4_sat  <= r_p3_sat;
            r_p4_view <= r_p3_view;
            r_p4_vox  <= r_p3_vox;
        end
    end

    // ---------------- stage P5: contribution ----------------
    logic [39:0]        cmag;
    logic signed [31:0] contrib;
    logic               sat2;

    always_comb begin
        cmag = r_p4_prod[47:8];
        sat2 = 1'b0;
        if (!r_p4_view) begin
            contrib = '0;
        end else if (r_p4_neg) begin
            if (cmag > 40'h00_8000_0000) begin
                sat2    = 1'b1;
                contrib = 32'sh8000_0000;
            end else begin
                contrib = -$signed(cmag[31:0]);
            end
        end else if (cmag > 40'h00_7FFF_FFFF) begin
            sat2    = 1'b1;
            contrib = 32'sh7FFF_FFFF;
        end else begin
            contrib = $signed(cmag[31:0]);
        end
    end

    logic               r_p5_v, r_p5_view, r_p5_sat;
    logic signed [31:0] r_p5_contrib;
    logic signed [31:0] r_p5_vox;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p5_contrib <= contrib;
            r_p5_sat     <= r_p4_sat || sat2;
            r_p5_view    <= r_p4_view;
            r_p5_vox     <= r_p4_vox;
        end
    end

    // ---------------- output: saturating accumulate ----------------
    logic signed [32:0] acc;
    logic signed [31:0] acc_clip;
    logic               sat3;

    always_comb begin
        acc  = 33'(r_p5_vox) + 33'(r_p5_contrib);
        sat3 = 1'b0;
        if (acc > 33'sd2147483647) begin
            sat3     = 1'b1;
            acc_clip = 32'sh7FFF_FFFF;
        end else if (acc < -33'sd2147483648) begin
            sat3     = 1'b1;
            acc_clip = 32'sh8000_0000;
        end else begin
            acc_clip = acc[31:0];
        end
    end

    logic signed [31:0] r_out_value, r_out_contrib;
    logic               r_out_view, r_out_sat;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_value   <= acc_clip;
            r_out_contrib <= r_p5_contrib;
            r_out_view    <= r_p5_view;
            r_out_sat     <= r_p5_sat || sat3;
        end
    end

    // valid bits; load words drop out after the store stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v      <= 1'b0;
            for (int s = 0; s <= QB; s++) r_sv[s] <= 1'b0;
            r_a_v       <= 1'b0;
            r_m_v       <= 1'b0;
            r_p1_v      <= 1'b0;
            r_p2_v      <= 1'b0;
            r_p3_v      <= 1'b0;
            r_p4_v      <= 1'b0;
            r_p5_v      <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_s1_v  <= i_in.valid;
            r_sv[0] <= r_s1_v;
            for (int s = 1; s <= QB; s++) r_sv[s] <= r_sv[s-1];
            r_a_v       <= r_sv[QB];
            r_m_v       <= r_a_v && !r_a_load;
            r_p1_v      <= r_m_v;
            r_p2_v      <= r_p1_v;
            r_p3_v      <= r_p2_v;
            r_p4_v      <= r_p3_v;
            r_p5_v      <= r_p4_v;
            r_out_valid <= r_p5_v;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.new_voxel_value = r_out_value;
    assign o_out.contribution    = r_out_contrib;
    assign o_out.in_view         = r_out_view;
    assign o_out.saturated       = r_out_sat;

endmodule

`default_nettype wire

FILE: bench/tsdf_voxel_depth_integration_core_tb.sv
// Testbench for tsdf_voxel_depth_integration_core: random and directed depth loads and voxel
// lookups, checked against a predictor of the depth map, ray potential and saturating update.
// Depends on tsdfv_pkg, tsdfv_in_if, tsdfv_out_if and the core itself.
`timescale 1ns / 100ps

module tsdf_voxel_depth_integration_core_tb;
    import tsdfv_pkg::*;

    // one input word and one result word, as the channels carry them
    typedef struct {
        logic               cmd;
        logic [9:0]         col;
        logic [9:0]         row;
        logic [31:0]        depth;
        logic [15:0]        weight;
        logic signed [47:0] hx;
        logic signed [47:0] hy;
        logic signed [47:0] hz;
        logic signed [31:0] vox;
    } t_voxel_word;

    typedef struct {
        logic signed [31:0] accum;
        logic signed [31:0] contrib;
        logic               in_view;
        logic               sat;
    } t_voxel_update;

    // Depth map mirror and accumulation predictor. Register copies follow the
    // writes that the bench makes; expected updates queue up in input order.
    class depth_map_scoreboard;
        bit [31:0]        trunc_dist, band, slope;
        bit [30:0]        peak, occluded;
        bit signed [31:0] freespace;
        bit [10:0]        cols, rows;
        bit [31:0]        depth_at[int];
        bit [15:0]        weight_at[int];
        int               loaded[$];
        t_voxel_update    due_updates[$];
        int               errors;

        function new();
            trunc_dist = 32'd655360;
            band       = 32'd1310720;
            slope      = 32'd3276;
            peak       = 31'd65536;
            freespace  = -32'sd65536;
            occluded   = 31'd655;
            cols       = 11'd1024;
            rows       = 11'd1024;
            errors     = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
            case (idx)
                REG_TRUNC_DISTANCE:  trunc_dist = data;
                REG_BAND_THICKNESS:  band = data;
                REG_BAND_SLOPE:      slope = data;
                REG_PEAK_MAGNITUDE:  peak = data[30:0];
                REG_FREESPACE_VALUE: freespace = data;
                REG_OCCLUDED_VALUE:  occluded = data[30:0];
                REG_IMAGE_WIDTH:     cols = data[10:0];
                REG_IMAGE_HEIGHT:    rows = data[10:0];
                default: ;
            endcase
        endfunction

        // store index of the pixel a voxel lands on, -1 for none
        function longint pixel_of(longint hx, longint hy, longint hz);
            longint u, v, cw, ch;
            if (hz == 0) return -1;
            u  = (2 * hx + hz) / (2 * hz);
            v  = (2 * hy + hz) / (2 * hz);
            cw = (cols < MAX_IMAGE_WIDTH) ? longint'(cols) : MAX_IMAGE_WIDTH;
            ch = (rows < MAX_IMAGE_HEIGHT) ? longint'(rows) : MAX_IMAGE_HEIGHT;
            if (u < 0 || u >= cw || v < 0 || v >= ch) return -1;
            return v * MAX_IMAGE_WIDTH + u;
        endfunction

        function longint clip32(longint v, inout bit sat);
            if (v > 64'sd2147483647) begin
                sat = 1;
                return 64'sd2147483647;
            end
            if (v < -64'sd2147483648) begin
                sat = 1;
                return -64'sd2147483648;
            end
            return v;
        endfunction

        // scale the magnitude, shift it down and put the sign back
        function longint scale(longint a, longint unsigned b, int sh);
            longint unsigned m, p;
            m = (a < 0) ? longint'(-a) : a;
            p = (m * b) >> sh;
            return (a < 0) ? -longint'(p) : longint'(p);
        endfunction

        function void note_word(t_voxel_word t);
            int            idx;
            longint        pix, diff, ad, pot, contrib;
            t_voxel_update r;
            bit            sat;
            if (t.cmd == CMD_LOAD) begin
                idx = int'(t.row) * MAX_IMAGE_WIDTH + int'(t.col);
                if (!depth_at.exists(idx)) loaded.push_back(idx);
                depth_at[idx]  = t.depth;
                weight_at[idx] = t.weight;
                return;
            end
            sat       = 0;
            r.accum   = t.vox;
            r.contrib = 0;
            r.in_view = 0;
            pix = pixel_of(t.hx, t.hy, t.hz);
            if (pix >= 0 && depth_at[int'(pix)] != 0 && weight_at[int'(pix)] != 0) begin
                r.in_view = 1;
                diff = longint'(t.hz) - longint'(depth_at[int'(pix)]);
                ad   = (diff < 0) ? -diff : diff;
                if (ad > longint'(trunc_dist))
                    pot = (diff > 0) ? longint'(occluded) : longint'(freespace);
                else if (ad > longint'(band))
                    pot = (diff > 0) ? longint'(peak) : -longint'(peak);
                else
                    pot = clip32(scale(diff, slope, 16), sat);
                contrib   = clip32(scale(pot, weight_at[int'(pix)], 8), sat);
                r.contrib = 32'(contrib);
                r.accum   = 32'(clip32(longint'(t.vox) + contrib, sat));
            end
            r.sat = sat;
            due_updates.push_back(r);
        endfunction

        function void check_result(t_voxel_update got);
            t_voxel_update want;
            if (due_updates.size() == 0) begin
                $display("%0t: update with none pending: accum %0d contrib %0d", $time,
                         got.accum, got.contrib);
                errors++;
                return;
            end
            want = due_updates.pop_front();
            if (got.accum !== want.accum) begin
                $display("%0t: accum expected %0d got %0d", $time, want.accum, got.accum);
                errors++;
            end
            if (got.contrib !== want.contrib) begin
                $display("%0t: contribution expected %0d got %0d", $time, want.contrib,
                         got.contrib);
                errors++;
            end
            if (got.in_view !== want.in_view) begin
                $display("%0t: in_view expected %0b got %0b", $time, want.in_view, got.in_view);
                errors++;
            end
            if (got.sat !== want.sat) begin
                $display("%0t: saturated expected %0b got %0b", $time, want.sat, got.sat);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    tsdfv_in_if  in_ch();
    tsdfv_out_if out_ch();

    tsdf_voxel_depth_integration_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    depth_map_scoreboard sb = new();
    bit no_idle;      // burst stretch: both sides skip their random gaps
    bit hold_req;     // ask the result side for one long hold-off
    int quiet_cycles;

    // Watchdog: count cycles in which neither channel moves a word.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= 3000) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic longint unsigned rnd_below(longint unsigned n);
        return {$urandom, $urandom} % n;
    endfunction

    function automatic int gap_draw();
        return no_idle ? 0 : $urandom_range(0, 12);
    endfunction

    // Result side: stall at random, hold off once for a long stretch on request.
    initial begin
        t_voxel_update got;
        int            n;
        out_ch.ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            n = gap_draw();
            if (hold_req) begin
                n = 300;
                hold_req = 0;
            end
            if (n > 0) begin
                out_ch.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            got.accum   = out_ch.new_voxel_value;
            got.contrib = out_ch.contribution;
            got.in_view = out_ch.in_view;
            got.sat     = out_ch.saturated;
            sb.check_result(got);
        end
    end

    // Offer one word after a random gap and hold it until taken.
    task automatic send_word(t_voxel_word t);
        int n;
        n = gap_draw();
        if (n > 0) begin
            in_ch.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.cmd           <= t.cmd;
        in_ch.pixel_col     <= t.col;
        in_ch.pixel_row     <= t.row;
        in_ch.depth_sample  <= t.depth;
        in_ch.weight_sample <= t.weight;
        in_ch.proj_x        <= t.hx;
        in_ch.proj_y        <= t.hy;
        in_ch.proj_z        <= t.hz;
        in_ch.voxel_value   <= t.vox;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_word(t);
    endtask

    // Drop valid, wait for every pending update, then let the pipe empty.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.due_updates.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    // Hold the write enable across back-to-back writes; write_all drops it.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
    endtask

    task automatic write_all(logic [31:0] td, logic [31:0] bt, logic [31:0] sl,
                             logic [31:0] pk, logic [31:0] fs, logic [31:0] oc,
                             logic [31:0] w, logic [31:0] h);
        write_reg(REG_TRUNC_DISTANCE, td);
        write_reg(REG_BAND_THICKNESS, bt);
        write_reg(REG_BAND_SLOPE, sl);
        write_reg(REG_PEAK_MAGNITUDE, pk);
        write_reg(REG_FREESPACE_VALUE, fs);
        write_reg(REG_OCCLUDED_VALUE, oc);
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        cfg_we <= 1'b0;
    endtask

    function automatic t_voxel_word load_word(int col, int row, logic [31:0] d,
                                              logic [15:0] w);
        t_voxel_word t;
        t     = '{default: '0};
        t.cmd = CMD_LOAD;
        t.col = 10'(col);
        t.row = 10'(row);
        t.depth  = d;
        t.weight = w;
        t.hx = 48'({$urandom, $urandom});
        t.vox = $urandom;
        return t;
    endfunction

    // Voxel whose projection rounds to (col,row); the offset stays inside the
    // rounding half-interval so the lookup lands on that pixel.
    function automatic t_voxel_word aim_word(longint col, longint row, longint hz,
                                             logic [31:0] vox, bit jitter);
        t_voxel_word    t;
        longint         m, lo, rx, ry;
        t     = '{default: '0};
        t.cmd = CMD_VOXEL;
        t.col = 10'($urandom);
        t.row = 10'($urandom);
        t.vox = vox;
        t.hz  = 48'(hz);
        m  = (hz < 0) ? -hz : hz;
        lo = m / 2;
        rx = 0;
        ry = 0;
        if (jitter && m > 0) begin
            rx = longint'(rnd_below(lo + (m - 1) / 2 + 1)) - lo;
            ry = longint'(rnd_below(lo + (m - 1) / 2 + 1)) - lo;
            if (hz < 0) begin
                rx = -rx;
                ry = -ry;
            end
        end
        t.hx = 48'(col * hz + rx);
        t.hy = 48'(row * hz + ry);
        return t;
    endfunction

    // Raw projection; redraw while it would land on a pixel never loaded.
    function automatic t_voxel_word noise_word(bit zero_scale);
        t_voxel_word t;
        longint      pix;
        t     = '{default: '0};
        t.cmd = CMD_VOXEL;
        t.vox = $urandom;
        do begin
            t.hx = 48'({$urandom, $urandom});
            t.hy = 48'({$urandom, $urandom});
            t.hz = zero_scale ? 48'sd0 : 48'({$urandom, $urandom});
            pix  = sb.pixel_of(t.hx, t.hy, t.hz);
        end while (pix >= 0 && !sb.depth_at.exists(int'(pix)));
        return t;
    endfunction

    // Voxel aimed at a loaded pixel, its depth placed in one potential region.
    function automatic t_voxel_word target_word();
        int                idx, col, row;
        longint unsigned   m, mag;
        longint            hz;
        for (int k = 0; k < 8; k++) begin
            idx = sb.loaded[$urandom_range(0, sb.loaded.size() - 1)];
            col = idx % MAX_IMAGE_WIDTH;
            row = idx / MAX_IMAGE_WIDTH;
            if (col < sb.cols && row < sb.rows) begin
                m = (sb.band < sb.trunc_dist) ? sb.band : sb.trunc_dist;
                case ($urandom_range(0, 3))
                    0: mag = rnd_below(m + 1);
                    1: mag = (sb.trunc_dist > m) ? m + 1 + rnd_below(sb.trunc_dist - m)
                                                 : rnd_below(m + 2);
                    2: mag = longint'(sb.trunc_dist) + 1 + rnd_below(64'd1 << 20);
                    default: mag = rnd_below(64'd1 << 34);
                endcase
                hz = longint'(sb.depth_at[idx]) + ($urandom_range(0, 1) ? -longint'(mag)
                                                                        : longint'(mag));
                if (hz == 0) return noise_word(1);
                return aim_word(col, row, hz, $urandom, 1);
            end
        end
        return noise_word(0);
    endfunction

    function automatic t_voxel_word random_word();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 30) begin
            if ($urandom_range(0, 9) < 7)
                return load_word($urandom_range(0, 15), $urandom_range(0, 15),
                                 ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom,
                                 ($urandom_range(0, 7) == 0) ? 16'd0 :
                                 ($urandom_range(0, 3) == 0) ? 16'd256 : 16'($urandom));
            return load_word($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom,
                             16'($urandom));
        end
        if (sel < 75) return target_word();
        if (sel < 82) return noise_word(1);
        return noise_word(0);
    endfunction

    task automatic random_phase(int count);
        for (int k = 0; k < count; k++) begin
            if (k % 40 == 0) no_idle = ($urandom_range(0, 2) == 0);
            send_word(random_word());
        end
        no_idle = 0;
    endtask

    initial begin
        logic [31:0] d0;
        i_rst_n          <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_idx          <= REG_TRUNC_DISTANCE;
        cfg_data         <= '0;
        in_ch.valid      <= 1'b0;
        in_ch.cmd        <= CMD_LOAD;
        in_ch.pixel_col  <= '0;
        in_ch.pixel_row  <= '0;
        in_ch.depth_sample  <= '0;
        in_ch.weight_sample <= '0;
        in_ch.proj_x     <= '0;
        in_ch.proj_y     <= '0;
        in_ch.proj_z     <= '0;
        in_ch.voxel_value <= '0;
        quiet_cycles     <= 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at reset settings: map corners, invalid pixels, the slope and
        // truncation potential regions, zero scale, off-image and clipping at both rails.
        d0 = 32'd5 << 16;
        send_word(load_word(0, 0, d0, 16'd256));
        send_word(load_word(1023, 1023, 32'hFFFF_FFFF, 16'hFFFF));
        send_word(load_word(1, 0, 32'd0, 16'd256));
        send_word(load_word(2, 0, 32'd1 << 16, 16'd0));
        send_word(load_word(3, 0, 32'd2 << 16, 16'hFFFF));
        send_word(noise_word(1));
        send_word(aim_word(0, 0, d0, 32'd1000, 0));
        send_word(aim_word(0, 0, d0 + (64'd1 << 16), 32'd0, 1));
        send_word(aim_word(0, 0, d0 - (64'd3 << 16), 32'd0, 1));
        send_word(aim_word(0, 0, d0 + (64'd100 << 16), 32'd0, 1));
        send_word(aim_word(0, 0, -(64'd100 << 16), 32'd0, 1));
        send_word(aim_word(1, 0, 64'd1 << 16, 32'd7, 1));
        send_word(aim_word(2, 0, 64'd1 << 16, 32'd7, 1));
        send_word(aim_word(1023, 1023, 64'd1 << 33, 32'h7FFF_FFFF, 0));
        send_word(aim_word(1023, 1023, 64'd1 << 20, 32'h7FFF_FFFF, 1));
        send_word(aim_word(3, 0, -(64'd1 << 30), 32'h8000_0000, 1));
        send_word(aim_word(-1, 0, 64'd1 << 16, 32'd5, 0));
        send_word(aim_word(1024, 0, 64'd1 << 16, 32'd5, 0));
        send_word(aim_word(0, 1024, -(64'd1 << 16), 32'd5, 0));
        drain();

        // Reset settings; the result side holds off once while words keep coming.
        hold_req = 1;
        random_phase(120);
        drain();

        // Everything at its top.
        write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                  32'h8000_0000, 32'h7FFF_FFFF, 32'd1024, 32'd1024);
        send_word(load_word(0, 0, 32'd1, 16'hFFFF));
        send_word(aim_word(0, 0, 64'hFFFF_FFFF, 32'h7FFF_0000, 1));
        send_word(aim_word(0, 0, -(64'hFFFF_FFFE), 32'h8000_0000, 1));
        random_phase(110);
        drain();

        // Everything at its bottom: one pixel in use.
        write_all(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd1, 32'd1);
        send_word(load_word(0, 0, 32'd9 << 16, 16'd256));
        random_phase(110);
        drain();

        // Random settings on small images, then a wide short one.
        write_all($urandom_range(0, 32'h00FF_FFFF), $urandom_range(0, 32'h00FF_FFFF),
                  $urandom, $urandom_range(0, 32'h7FFF_FFFF), -$urandom_range(0, 32'h7FFF_FFFF),
                  $urandom_range(0, 32'h7FFF_FFFF), $urandom_range(1, 16),
                  $urandom_range(1, 16));
        random_phase(120);
        drain();
        write_all($urandom, $urandom_range(0, 32'h0FFF_FFFF), $urandom_range(0, 32'hFFFF),
                  $urandom_range(0, 32'h7FFF_FFFF), -$urandom_range(0, 32'h7FFF_FFFF),
                  $urandom_range(0, 32'h7FFF_FFFF), 32'd1024, $urandom_range(1, 16));
        random_phase(120);
        drain();

        if (sb.errors == 0 && sb.due_updates.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/tsdfv_pkg.sv
rtl/core/tsdfv_in_if.sv
rtl/core/tsdfv_out_if.sv
rtl/core/tsdfv_div.sv
rtl/core/tsdf_voxel_depth_integration_core.sv
bench/tsdf_voxel_depth_integration_core_tb.sv
